// ===== rtl/ptf_pkg.sv =====
// Shared constants and codes for the page table with FIFO replacement.
`default_nettype none

package ptf_pkg;

   // Default sizes of the block.
   localparam int PROCESSES_DEF = 8;
   localparam int PAGES_DEF     = 64;
   localparam int FRAMES_DEF    = 256;

   // Fixed widths of the transaction fields.
   localparam int FUNC_W    = 2;
   localparam int PROC_W    = 3;
   localparam int PAGE_W    = 6;
   localparam int FRAME_W   = 8;
   localparam int LIMIT_W   = 7;
   localparam int STATUS_W  = 3;
   localparam int TOTAL_W   = 32;
   localparam int STAMP_W   = 32;
   localparam int CLOCK_W   = 31;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FN_ACCESS  = 2'd0;
   localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
   localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] RS_HIT      = 3'd0;
   localparam logic [STATUS_W-1:0] RS_FAULT    = 3'd1;
   localparam logic [STATUS_W-1:0] RS_ILLEGAL  = 3'd2;
   localparam logic [STATUS_W-1:0] RS_RELEASED = 3'd3;
   localparam logic [STATUS_W-1:0] RS_ALLOC    = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/page_table_fifo_fault_handler.sv =====
// Top level: per-process page table with FIFO page replacement on faults.
//
//  Channel   Ports                          Handshake
//  --------  -----------------------------  ---------------------------------------------
//  request   req_* (six fields)             taken at a rising edge with start high, busy low
//  response  rsp_* (four fields)            one cycle while rsp_strobe is high, no stall
//
// One transaction is in flight at a time; busy is high from acceptance until the response.
// On a fault the stamps of the process's range are scanned one frame per cycle, then its
// page table is swept. After reset a clearing pass over every address of the larger
// memory zeroes both memories with busy high. The receiver cannot stall, so no response
// waits.
`default_nettype none

module page_table_fifo_fault_handler
   import ptf_pkg::*;
#(
   parameter int PROCESSES = PROCESSES_DEF,
   parameter int PAGES     = PAGES_DEF,
   parameter int FRAMES    = FRAMES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [PROC_W-1:0]   req_process,
   input  wire logic [PAGE_W-1:0]   req_page,
   input  wire logic [FRAME_W-1:0]  req_first_frame,
   input  wire logic [FRAME_W-1:0]  req_last_frame,
   input  wire logic [LIMIT_W-1:0]  req_page_limit,
   output logic                     rsp_strobe,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [FRAME_W-1:0]       rsp_frame,
   output logic [TOTAL_W-1:0]       rsp_fault_total,
   output logic [TOTAL_W-1:0]       rsp_illegal_total
);

   // Derived sizes.
   localparam int ENTRIES = PROCESSES * PAGES;
   localparam int CLR_N   = (ENTRIES > FRAMES) ? ENTRIES : FRAMES;
   localparam int PR_W    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
   localparam int PG_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int FR_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int EA_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LP_W    = $clog2(PAGES + 1);
   localparam int CL_W    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
   localparam int EW      = FR_W + 1;

   // Sequencer states.
   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DISPATCH = 4'd2;
   localparam logic [3:0] S_LOOKUP   = 4'd3;
   localparam logic [3:0] S_SCAN     = 4'd4;
   localparam logic [3:0] S_STAMP    = 4'd5;
   localparam logic [3:0] S_INVAL    = 4'd6;
   localparam logic [3:0] S_MAP      = 4'd7;
   localparam logic [3:0] S_RELEASE  = 4'd8;

   // Sequencer and working registers.
   logic [3:0]           state_ff, state_in;
   logic [CL_W-1:0]      clr_idx_ff, clr_idx_in;
   logic [FUNC_W-1:0]    func_ff, func_in;
   logic [PROC_W-1:0]    proc_ff, proc_in;
   logic [PAGE_W-1:0]    page_ff, page_in;
   logic [FRAME_W-1:0]   first_req_ff, first_req_in;
   logic [FRAME_W-1:0]   last_req_ff, last_req_in;
   logic [LIMIT_W-1:0]   limit_req_ff, limit_req_in;
   logic [FR_W-1:0]      first_ff, first_in;
   logic [FR_W-1:0]      last_ff, last_in;
   logic [EA_W-1:0]      base_ff, base_in;
   logic [FR_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [STAMP_W-1:0]   best_stamp_ff, best_stamp_in;
   logic [FR_W-1:0]      victim_ff, victim_in;
   logic [PG_W-1:0]      inv_idx_ff, inv_idx_in;
   logic [CLOCK_W-1:0]   clock_ff, clock_in;

   // Response registers.
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [FRAME_W-1:0]   rsp_frame_ff, rsp_frame_in;
   logic [TOTAL_W-1:0]   rsp_fault_ff, rsp_fault_in;
   logic [TOTAL_W-1:0]   rsp_illegal_ff, rsp_illegal_in;

   // Per-process registers.
   logic [FR_W-1:0]      range_first_ff [PROCESSES];
   logic [FR_W-1:0]      range_last_ff [PROCESSES];
   logic [LP_W-1:0]      legal_ff [PROCESSES];
   logic [TOTAL_W-1:0]   faults_ff [PROCESSES];
   logic [TOTAL_W-1:0]   illegals_ff [PROCESSES];

   // Update strobes for the per-process registers.
   logic                 alloc_we;
   logic                 fault_inc;
   logic                 illegal_inc;

   // Memory ports.
   logic                 ent_we;
   logic [EA_W-1:0]      ent_waddr;
   logic [EW-1:0]        ent_wdata;
   logic [EA_W-1:0]      ent_raddr;
   logic [EW-1:0]        ent_rdata;
   logic                 stp_we;
   logic [FR_W-1:0]      stp_waddr;
   logic [STAMP_W-1:0]   stp_wdata;
   logic [FR_W-1:0]      stp_raddr;
   logic [STAMP_W-1:0]   stp_rdata;

   // Decoded values of the transaction in hand.
   logic [PR_W-1:0]      pidx;
   logic                 p_ok;
   logic                 page_bad;
   logic [EA_W-1:0]      base_c;
   logic [FR_W-1:0]      first_sat;
   logic [FR_W-1:0]      last_sat;
   logic [LP_W-1:0]      limit_sat;
   logic                 scan_take;

   // Table entries: valid bit above the frame number.
   ptf_ram #(
      .WIDTH (EW),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   // Load stamps, one per frame, compared as signed values.
   ptf_ram #(
      .WIDTH (STAMP_W),
      .DEPTH (FRAMES)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stp_we),
      .wr_addr (stp_waddr),
      .wr_data (stp_wdata),
      .rd_addr (stp_raddr),
      .rd_data (stp_rdata)
   );

   assign pidx      = PR_W'(proc_ff);
   assign p_ok      = 32'(proc_ff) < PROCESSES;
   assign base_c    = EA_W'(32'(proc_ff) * PAGES);
   assign page_bad  = (32'(page_ff) >= 32'(legal_ff[pidx])) || (32'(page_ff) >= PAGES);
   assign first_sat = (32'(first_req_ff) >= FRAMES) ? FR_W'(FRAMES - 1) : FR_W'(first_req_ff);
   assign last_sat  = (32'(last_req_ff) >= FRAMES) ? FR_W'(FRAMES - 1) : FR_W'(last_req_ff);
   assign limit_sat = (32'(limit_req_ff) > PAGES) ? LP_W'(PAGES) : LP_W'(limit_req_ff);

   // The first frame of the range always wins; later frames only on a strictly older
   // stamp, so the lowest frame is kept on ties.
   assign scan_take = (cmp_idx_ff == first_ff) ||
                      ($signed(stp_rdata) < $signed(best_stamp_ff));

   always_comb begin
      state_in       = state_ff;
      clr_idx_in     = clr_idx_ff;
      func_in        = func_ff;
      proc_in        = proc_ff;
      page_in        = page_ff;
      first_req_in   = first_req_ff;
      last_req_in    = last_req_ff;
      limit_req_in   = limit_req_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      base_in        = base_ff;
      cmp_idx_in     = cmp_idx_ff;
      best_stamp_in  = best_stamp_ff;
      victim_in      = victim_ff;
      inv_idx_in     = inv_idx_ff;
      clock_in       = clock_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_fault_in   = rsp_fault_ff;
      rsp_illegal_in = rsp_illegal_ff;
      alloc_we       = 1'b0;
      fault_inc      = 1'b0;
      illegal_inc    = 1'b0;
      ent_we         = 1'b0;
      ent_waddr      = base_ff;
      ent_wdata      = '0;
      ent_raddr      = base_ff;
      stp_we         = 1'b0;
      stp_waddr      = cmp_idx_ff;
      stp_wdata      = '0;
      stp_raddr      = cmp_idx_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // Both memories are zeroed together, one address per cycle.
            ent_we    = 32'(clr_idx_ff) < ENTRIES;
            ent_waddr = EA_W'(clr_idx_ff);
            stp_we    = 32'(clr_idx_ff) < FRAMES;
            stp_waddr = FR_W'(clr_idx_ff);
            if (clr_idx_ff == CL_W'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (start) begin
               func_in      = req_func;
               proc_in      = req_process;
               page_in      = req_page;
               first_req_in = req_first_frame;
               last_req_in  = req_last_frame;
               limit_req_in = req_page_limit;
               state_in     = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            first_in = range_first_ff[pidx];
            last_in  = range_last_ff[pidx];
            base_in  = base_c;
            if (!p_ok) begin
               // A process beyond the table touches nothing and reports zero totals.
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = RS_ILLEGAL;
               rsp_frame_in   = '0;
               rsp_fault_in   = '0;
               rsp_illegal_in = '0;
               state_in       = S_IDLE;
            end else begin
               rsp_fault_in   = faults_ff[pidx];
               rsp_illegal_in = illegals_ff[pidx];
               rsp_frame_in   = '0;
               unique case (func_ff)
                  FN_ALLOC: begin
                     alloc_we      = 1'b1;
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = RS_ALLOC;
                     state_in      = S_IDLE;
                  end
                  FN_RELEASE: begin
                     if (range_first_ff[pidx] <= range_last_ff[pidx]) begin
                        cmp_idx_in = range_first_ff[pidx];
                        state_in   = S_RELEASE;
                     end else begin
                        // An empty range releases nothing but still ticks the clock.
                        clock_in      = clock_ff + 1'b1;
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = RS_RELEASED;
                        state_in      = S_IDLE;
                     end
                  end
                  FN_ACCESS: begin
                     if (page_bad) begin
                        illegal_inc    = 1'b1;
                        clock_in       = clock_ff + 1'b1;
                        rsp_strobe_in  = 1'b1;
                        rsp_status_in  = RS_ILLEGAL;
                        rsp_illegal_in = illegals_ff[pidx] + 1'b1;
                        state_in       = S_IDLE;
                     end else begin
                        ent_raddr = base_c + EA_W'(page_ff);
                        state_in  = S_LOOKUP;
                     end
                  end
                  default: begin
                     // The unused function code is answered as illegal and changes nothing.
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = RS_ILLEGAL;
                     state_in      = S_IDLE;
                  end
               endcase
            end
         end

         S_LOOKUP: begin
            if (ent_rdata[FR_W]) begin
               clock_in       = clock_ff + 1'b1;
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = RS_HIT;
               rsp_frame_in   = FRAME_W'(ent_rdata[FR_W-1:0]);
               rsp_fault_in   = faults_ff[pidx];
               rsp_illegal_in = illegals_ff[pidx];
               state_in       = S_IDLE;
            end else begin
               fault_inc = 1'b1;
               if (first_ff <= last_ff) begin
                  cmp_idx_in = first_ff;
                  stp_raddr  = first_ff;
                  state_in   = S_SCAN;
               end else begin
                  // With an empty range the first frame is taken without a scan.
                  victim_in = first_ff;
                  state_in  = S_STAMP;
               end
            end
         end

         S_SCAN: begin
            // The stamp of cmp_idx_ff arrives now; the next frame is read meanwhile.
            if (scan_take) begin
               best_stamp_in = stp_rdata;
               victim_in     = cmp_idx_ff;
            end
            if (cmp_idx_ff == last_ff) begin
               state_in = S_STAMP;
            end else begin
               cmp_idx_in = cmp_idx_ff + 1'b1;
               stp_raddr  = cmp_idx_ff + 1'b1;
            end
         end

         S_STAMP: begin
            stp_we     = 1'b1;
            stp_waddr  = victim_ff;
            stp_wdata  = {1'b0, clock_ff};
            ent_raddr  = base_ff;
            inv_idx_in = '0;
            state_in   = S_INVAL;
         end

         S_INVAL: begin
            // Read-modify-write sweep: the entry read last cycle is cleared if it names
            // the victim, while the next entry is read.
            if (ent_rdata[FR_W-1:0] == victim_ff) begin
               ent_we    = 1'b1;
               ent_waddr = base_ff + EA_W'(inv_idx_ff);
               ent_wdata = {1'b0, ent_rdata[FR_W-1:0]};
            end
            if (inv_idx_ff == PG_W'(PAGES - 1)) begin
               state_in = S_MAP;
            end else begin
               inv_idx_in = inv_idx_ff + 1'b1;
               ent_raddr  = base_ff + EA_W'(PG_W'(inv_idx_ff + 1'b1));
            end
         end

         S_MAP: begin
            ent_we         = 1'b1;
            ent_waddr      = base_ff + EA_W'(page_ff);
            ent_wdata      = {1'b1, victim_ff};
            clock_in       = clock_ff + 1'b1;
            rsp_strobe_in  = 1'b1;
            rsp_status_in  = RS_FAULT;
            rsp_frame_in   = FRAME_W'(victim_ff);
            rsp_fault_in   = faults_ff[pidx];
            rsp_illegal_in = illegals_ff[pidx];
            state_in       = S_IDLE;
         end

         S_RELEASE: begin
            // Released frames take the stamp -1, older than any load.
            stp_we    = 1'b1;
            stp_waddr = cmp_idx_ff;
            stp_wdata = '1;
            if (cmp_idx_ff == last_ff) begin
               clock_in       = clock_ff + 1'b1;
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = RS_RELEASED;
               rsp_frame_in   = '0;
               rsp_fault_in   = faults_ff[pidx];
               rsp_illegal_in = illegals_ff[pidx];
               state_in       = S_IDLE;
            end else begin
               cmp_idx_in = cmp_idx_ff + 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_idx_ff    <= '0;
         clock_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         clock_ff      <= clock_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      proc_ff        <= proc_in;
      page_ff        <= page_in;
      first_req_ff   <= first_req_in;
      last_req_ff    <= last_req_in;
      limit_req_ff   <= limit_req_in;
      first_ff       <= first_in;
      last_ff        <= last_in;
      base_ff        <= base_in;
      cmp_idx_ff     <= cmp_idx_in;
      best_stamp_ff  <= best_stamp_in;
      victim_ff      <= victim_in;
      inv_idx_ff     <= inv_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_fault_ff   <= rsp_fault_in;
      rsp_illegal_ff <= rsp_illegal_in;
   end

   // Per-process ranges, limits and counters are architectural state cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PROCESSES; i++) begin
            range_first_ff[i] <= '0;
            range_last_ff[i]  <= '0;
            legal_ff[i]       <= '0;
            faults_ff[i]      <= '0;
            illegals_ff[i]    <= '0;
         end
      end else begin
         if (alloc_we) begin
            range_first_ff[pidx] <= first_sat;
            range_last_ff[pidx]  <= last_sat;
            legal_ff[pidx]       <= limit_sat;
         end
         if (fault_inc) begin
            faults_ff[pidx] <= faults_ff[pidx] + 1'b1;
         end
         if (illegal_inc) begin
            illegals_ff[pidx] <= illegals_ff[pidx] + 1'b1;
         end
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_frame         = rsp_frame_ff;
   assign rsp_fault_total   = rsp_fault_ff;
   assign rsp_illegal_total = rsp_illegal_ff;

endmodule

`default_nettype wire

// ===== rtl/ptf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ptf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the page table with FIFO replacement on page faults.

module testbench;
   import ptf_pkg::*;

   // Sizes of the block as instantiated (the package defaults).
   localparam int PROCESSES = PROCESSES_DEF;
   localparam int PAGES     = PAGES_DEF;
   localparam int FRAMES    = FRAMES_DEF;

   // The fourth function code has no meaning to the block; it answers it as illegal.
   localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 1725;
   // The longest transaction is a fault over the whole frame store; after the last
   // response we listen a little longer than that for stray strobes.
   localparam int SETTLE_CYCLES = 400;
   // Worst case: every transaction a full-range fault after the longest idle gap, plus the
   // clearing pass after reset, taken several times over.
   localparam int CYCLE_LIMIT   = 6_000_000;

   // One response transaction as the block presents it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FRAME_W-1:0]  frame;
      logic [TOTAL_W-1:0]  fault_total;
      logic [TOTAL_W-1:0]  illegal_total;
   } outcome_type;

   // One row of the directed table. Where typed is set the response is written out by
   // hand; otherwise the translation model below supplies it.
   typedef struct packed {
      logic [FUNC_W-1:0]  fn;
      logic [PROC_W-1:0]  pr;
      logic [PAGE_W-1:0]  pg;
      logic [FRAME_W-1:0] ff;
      logic [FRAME_W-1:0] lf;
      logic [LIMIT_W-1:0] lim;
      bit                 typed;
      outcome_type        outcome;
   } stim_row_type;

   // Every input is given a known value from time zero.
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [PROC_W-1:0]   req_process = '0;
   logic [PAGE_W-1:0]   req_page = '0;
   logic [FRAME_W-1:0]  req_first_frame = '0;
   logic [FRAME_W-1:0]  req_last_frame = '0;
   logic [LIMIT_W-1:0]  req_page_limit = '0;
   logic                busy;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [FRAME_W-1:0]  rsp_frame;
   logic [TOTAL_W-1:0]  rsp_fault_total;
   logic [TOTAL_W-1:0]  rsp_illegal_total;

   // Our own copy of the block's state, kept in step with every accepted transaction.
   logic [FRAME_W-1:0]        map_frame [PROCESSES*PAGES];
   bit                        map_valid [PROCESSES*PAGES];
   logic signed [STAMP_W-1:0] load_stamp [FRAMES];
   logic [FRAME_W-1:0]        span_first [PROCESSES];
   logic [FRAME_W-1:0]        span_last [PROCESSES];
   logic [LIMIT_W-1:0]        page_limit_of [PROCESSES];
   logic [TOTAL_W-1:0]        fault_count [PROCESSES];
   logic [TOTAL_W-1:0]        illegal_count [PROCESSES];
   logic [CLOCK_W-1:0]        access_tick;

   // Responses still owed by the block, oldest first.
   outcome_type pending_outcomes [$];

   int  mismatch_count = 0;
   int  response_count = 0;
   int  hit_count = 0;
   int  fault_seen_count = 0;
   int  illegal_seen_count = 0;
   int  release_count = 0;
   int  alloc_count = 0;
   int  cycle_count = 0;
   bit  no_idle = 1'b0;

   page_table_fifo_fault_handler dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_process       (req_process),
      .req_page          (req_page),
      .req_first_frame   (req_first_frame),
      .req_last_frame    (req_last_frame),
      .req_page_limit    (req_page_limit),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_frame         (rsp_frame),
      .rsp_fault_total   (rsp_fault_total),
      .rsp_illegal_total (rsp_illegal_total)
   );

   always #1 clock = ~clock;

   // Works out the response to one accepted request and updates the shadow state.
   // Stamps compare as signed values, so a released frame (all ones) is chosen before any
   // loaded one, and the lowest frame wins a tie. An empty range (first above last) leaves
   // the first frame as victim and makes a release a no-op on the stamps.
   function automatic outcome_type translate_request(input logic [FUNC_W-1:0] fn,
                                                     input logic [PROC_W-1:0] pr,
                                                     input logic [PAGE_W-1:0] pg,
                                                     input logic [FRAME_W-1:0] ff,
                                                     input logic [FRAME_W-1:0] lf,
                                                     input logic [LIMIT_W-1:0] lim);
      outcome_type        o;
      int                 base;
      int                 idx;
      logic [FRAME_W-1:0] victim;
      base = pr * PAGES;
      o = '0;
      o.status = RS_ILLEGAL;
      case (fn)
         FN_ALLOC: begin
            // The frame fields cannot exceed the last frame at eight bits, so only the
            // page limit needs to be clipped.
            span_first[pr] = ff;
            span_last[pr] = lf;
            page_limit_of[pr] = (lim > PAGES) ? LIMIT_W'(PAGES) : lim;
            o.status = RS_ALLOC;
         end
         FN_RELEASE: begin
            for (idx = span_first[pr]; idx <= span_last[pr]; idx++) begin
               load_stamp[idx] = '1;
            end
            access_tick++;
            o.status = RS_RELEASED;
         end
         FN_ACCESS: begin
            if (pg >= page_limit_of[pr]) begin
               illegal_count[pr]++;
            end else if (map_valid[base + pg]) begin
               o.status = RS_HIT;
               o.frame = map_frame[base + pg];
            end else begin
               fault_count[pr]++;
               victim = span_first[pr];
               for (idx = span_first[pr]; idx <= span_last[pr]; idx++) begin
                  if (load_stamp[idx] < load_stamp[victim]) victim = idx[FRAME_W-1:0];
               end
               // Any other page of this process that still maps the victim loses it.
               for (idx = 0; idx < PAGES; idx++) begin
                  if (map_frame[base + idx] == victim) map_valid[base + idx] = 1'b0;
               end
               load_stamp[victim] = {1'b0, access_tick};
               map_frame[base + pg] = victim;
               map_valid[base + pg] = 1'b1;
               o.status = RS_FAULT;
               o.frame = victim;
            end
            access_tick++;
         end
         default: ;
      endcase
      o.fault_total = fault_count[pr];
      o.illegal_total = illegal_count[pr];
      return o;
   endfunction

   function automatic stim_row_type plan_row(input logic [FUNC_W-1:0] fn,
                                             input logic [PROC_W-1:0] pr,
                                             input logic [PAGE_W-1:0] pg,
                                             input logic [FRAME_W-1:0] ff,
                                             input logic [FRAME_W-1:0] lf,
                                             input logic [LIMIT_W-1:0] lim,
                                             input bit typed,
                                             input logic [STATUS_W-1:0] st,
                                             input logic [FRAME_W-1:0] fr,
                                             input logic [TOTAL_W-1:0] ft,
                                             input logic [TOTAL_W-1:0] it);
      stim_row_type r;
      r.fn = fn;
      r.pr = pr;
      r.pg = pg;
      r.ff = ff;
      r.lf = lf;
      r.lim = lim;
      r.typed = typed;
      r.outcome = {st, fr, ft, it};
      return r;
   endfunction

   // Presents one request transaction and holds it until the block takes it. Before
   // raising start we may idle at random: mostly a few cycles, sometimes long enough to
   // land anywhere inside a full fault scan. Start is left high on return, so a
   // back-to-back transaction never lowers and raises it within one time step.
   task automatic issue_request(input logic [FUNC_W-1:0] fn,
                                input logic [PROC_W-1:0] pr,
                                input logic [PAGE_W-1:0] pg,
                                input logic [FRAME_W-1:0] ff,
                                input logic [FRAME_W-1:0] lf,
                                input logic [LIMIT_W-1:0] lim,
                                input bit typed,
                                input outcome_type typed_outcome);
      outcome_type predicted;
      int          gap;
      gap = 0;
      if (!no_idle && $urandom_range(0, 99) < 21) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 6);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= fn;
      req_process <= pr;
      req_page <= pg;
      req_first_frame <= ff;
      req_last_frame <= lf;
      req_page_limit <= lim;
      // The transaction is taken at the first edge that sees busy low.
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predicted = translate_request(fn, pr, pg, ff, lf, lim);
      pending_outcomes.push_back(typed ? typed_outcome : predicted);
   endtask

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   // Response checker. The strobe and fields are sampled at the edge that ends the
   // response cycle; each response is matched against the oldest outstanding expectation.
   always @(posedge clock) begin : check_response
      outcome_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         response_count++;
         case (rsp_status)
            RS_HIT:      hit_count++;
            RS_FAULT:    fault_seen_count++;
            RS_ILLEGAL:  illegal_seen_count++;
            RS_RELEASED: release_count++;
            RS_ALLOC:    alloc_count++;
            default: ;
         endcase
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            $display("%0t: response with nothing outstanding, expected none, got status %0d",
                     $time, rsp_status);
         end else begin
            want = pending_outcomes.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_status));
            compare_field("frame", 32'(want.frame), 32'(rsp_frame));
            compare_field("fault_total", want.fault_total, rsp_fault_total);
            compare_field("illegal_total", want.illegal_total, rsp_illegal_total);
         end
      end
   end

   // Watchdog: a hung handshake or a missing response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type       plan [DIRECTED_ROWS];
      outcome_type        nothing;
      int                 row;
      int                 issued;
      int                 pick;
      bit                 paused;
      logic [FUNC_W-1:0]  fn;
      logic [PROC_W-1:0]  pr;
      logic [PAGE_W-1:0]  pg;
      logic [FRAME_W-1:0] ff;
      logic [FRAME_W-1:0] lf;
      logic [LIMIT_W-1:0] lim;

      // The shadow state starts out as the block leaves it after its clearing pass.
      foreach (map_frame[i]) begin
         map_frame[i] = '0;
         map_valid[i] = 1'b0;
      end
      foreach (load_stamp[i]) load_stamp[i] = '0;
      foreach (span_first[i]) begin
         span_first[i] = '0;
         span_last[i] = '0;
         page_limit_of[i] = '0;
         fault_count[i] = '0;
         illegal_count[i] = '0;
      end
      access_tick = '0;
      nothing = '0;

      // Directed table. The early rows start from the cleared state, where every process
      // has a one-frame range at frame zero and no legal pages.
      plan[0]  = plan_row(FN_ACCESS, 0, 0, 0, 0, 0, 1, RS_ILLEGAL, 0, 0, 1);
      plan[1]  = plan_row(FN_RELEASE, 0, 0, 0, 0, 0, 1, RS_RELEASED, 0, 0, 1);
      plan[2]  = plan_row(FN_SPARE, 0, 0, 0, 0, 0, 1, RS_ILLEGAL, 0, 0, 1);
      plan[3]  = plan_row(FN_ALLOC, 0, 0, 0, 3, 4, 1, RS_ALLOC, 0, 0, 1);
      // The released frame zero is the oldest, so the first fault lands there.
      plan[4]  = plan_row(FN_ACCESS, 0, 0, 0, 0, 0, 1, RS_FAULT, 0, 1, 1);
      plan[5]  = plan_row(FN_ACCESS, 0, 0, 0, 0, 0, 1, RS_HIT, 0, 1, 1);
      plan[6]  = plan_row(FN_ACCESS, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
      plan[7]  = plan_row(FN_ACCESS, 0, 3, 0, 0, 0, 0, 0, 0, 0, 0);
      // The page equal to the limit, then the highest page.
      plan[8]  = plan_row(FN_ACCESS, 0, 4, 0, 0, 0, 0, 0, 0, 0, 0);
      plan[9]  = plan_row(FN_ACCESS, 0, 63, 0, 0, 0, 0, 0, 0, 0, 0);
      // Top frame and an over-large page limit, which is clipped to the page count.
      plan[10] = plan_row(FN_ALLOC, 1, 0, 255, 255, 127, 1, RS_ALLOC, 0, 0, 0);
      plan[11] = plan_row(FN_ACCESS, 1, 63, 0, 0, 0, 1, RS_FAULT, 255, 1, 0);
      plan[12] = plan_row(FN_ACCESS, 1, 63, 0, 0, 0, 1, RS_HIT, 255, 1, 0);
      // An empty range: faults always evict the first frame and a release frees nothing.
      plan[13] = plan_row(FN_ALLOC, 7, 0, 200, 100, 64, 1, RS_ALLOC, 0, 0, 0);
      plan[14] = plan_row(FN_ACCESS, 7, 10, 0, 0, 0, 1, RS_FAULT, 200, 1, 0);
      plan[15] = plan_row(FN_RELEASE, 7, 0, 0, 0, 0, 1, RS_RELEASED, 0, 1, 0);
      plan[16] = plan_row(FN_ACCESS, 7, 11, 0, 0, 0, 0, 0, 0, 0, 0);
      plan[17] = plan_row(FN_ACCESS, 7, 10, 0, 0, 0, 0, 0, 0, 0, 0);
      // The whole frame store with no legal pages, then with all of them.
      plan[18] = plan_row(FN_ALLOC, 2, 0, 0, 255, 0, 1, RS_ALLOC, 0, 0, 0);
      plan[19] = plan_row(FN_ACCESS, 2, 0, 0, 0, 0, 1, RS_ILLEGAL, 0, 0, 1);
      plan[20] = plan_row(FN_ALLOC, 2, 0, 0, 255, 64, 1, RS_ALLOC, 0, 0, 1);
      plan[21] = plan_row(FN_ACCESS, 2, 5, 0, 0, 0, 0, 0, 0, 0, 0);
      // A release keeps mappings but makes the range the first choice for eviction.
      plan[22] = plan_row(FN_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      plan[23] = plan_row(FN_ACCESS, 0, 2, 0, 0, 0, 0, 0, 0, 0, 0);
      plan[24] = plan_row(FN_SPARE, 3, 63, 255, 255, 127, 1, RS_ILLEGAL, 0, 0, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // The block holds busy through its clearing pass, so the first transaction simply
      // waits for it.
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         issue_request(plan[row].fn, plan[row].pr, plan[row].pg, plan[row].ff,
                       plan[row].lf, plan[row].lim, plan[row].typed, plan[row].outcome);
      end

      // Random part. It opens with an allocation for every process so that most accesses
      // afterwards are legal, then mixes accesses over a small working set of pages (so
      // that hits and FIFO evictions both occur) with releases, reallocations, the spare
      // code and some wholly random pages.
      issued = 0;
      paused = 1'b0;
      while (issued < RANDOM_ITEMS) begin
         no_idle = (issued >= 300 && issued < 700);
         if (issued == 850 && !paused) begin
            // Let the block drain completely before carrying on.
            paused = 1'b1;
            start <= 1'b0;
            while (pending_outcomes.size() != 0) @(posedge clock);
         end
         pr = PROC_W'($urandom_range(0, PROCESSES - 1));
         pg = PAGE_W'($urandom_range(0, PAGES - 1));
         ff = FRAME_W'($urandom_range(0, FRAMES - 1));
         lf = FRAME_W'($urandom_range(0, FRAMES - 1));
         lim = LIMIT_W'($urandom_range(0, 127));
         pick = $urandom_range(0, 99);
         if (issued < PROCESSES) begin
            pr = PROC_W'(issued);
            pick = 90;
         end
         if (pick < 75) begin
            fn = FN_ACCESS;
            if (page_limit_of[pr] != 0 && $urandom_range(0, 9) != 0) begin
               pg = PAGE_W'($urandom_range(0, (page_limit_of[pr] > 12) ? 11 :
                                              page_limit_of[pr] - 1));
            end
         end else if (pick < 83) begin
            fn = FN_RELEASE;
         end else if (pick < 92) begin
            fn = FN_ALLOC;
            // Mostly small ranges keep faults short; now and then an arbitrary (possibly
            // empty) range or the whole frame store.
            case ($urandom_range(0, 19))
               0, 1, 2: ;
               3: begin
                  ff = '0;
                  lf = '1;
               end
               default: lf = (ff > 247) ? 8'd255 : ff + 8'($urandom_range(0, 7));
            endcase
            if ($urandom_range(0, 3) != 0) lim = LIMIT_W'($urandom_range(1, PAGES));
         end else begin
            fn = FN_SPARE;
         end
         issue_request(fn, pr, pg, ff, lf, lim, 1'b0, nothing);
         issued++;
      end

      // Drain: wait for every outstanding response, then watch a while for stray strobes.
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d responses: %0d hits, %0d faults, %0d illegal or spare,",
               response_count, hit_count, fault_seen_count, illegal_seen_count);
      $display("%0d releases and %0d allocations; %0d field mismatches.",
               release_count, alloc_count, mismatch_count);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== page_table_fifo_fault_handler.f =====
rtl/ptf_pkg.sv
rtl/ptf_ram.sv
rtl/page_table_fifo_fault_handler.sv
tb/sv/testbench.sv
